// ===== rtl/lspc_pkg.sv =====
// Shared types, codes and the steering table for the line-sensor pattern classifier.
package lspc_pkg;

    // Field widths.
    localparam int PIN_W    = 5;
    localparam int STEER_W  = 13;
    localparam int NORM_W   = 10;
    localparam int STATUS_W = 3;
    localparam int LOST_W   = 8;
    localparam int MAJ_W    = 4;
    localparam int CFG_W    = 8;
    localparam int IDX_W    = 1;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 48;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_MAJORITY_SAMPLES = 1'd0;
    localparam logic [IDX_W-1:0] REG_LOST_THRESHOLD   = 1'd1;

    // Values that stand in for a zero register, and the saturation value of the lost count.
    localparam logic [MAJ_W-1:0]  DEFAULT_SAMPLES   = 4'd3;
    localparam logic [LOST_W-1:0] DEFAULT_THRESHOLD = 8'd3;
    localparam logic [LOST_W-1:0] LOST_SAT          = 8'hFF;

    // Named patterns, bit 4 is the far-left sensor.
    localparam logic [PIN_W-1:0] PAT_WHITE      = 5'h00;
    localparam logic [PIN_W-1:0] PAT_BLACK      = 5'h1F;
    localparam logic [PIN_W-1:0] PAT_CENTER     = 5'h04;
    localparam logic [PIN_W-1:0] PAT_LEFT_MID   = 5'h0C;
    localparam logic [PIN_W-1:0] PAT_RIGHT_MID  = 5'h06;
    localparam logic [PIN_W-1:0] PAT_LEFT_IN    = 5'h08;
    localparam logic [PIN_W-1:0] PAT_RIGHT_IN   = 5'h02;
    localparam logic [PIN_W-1:0] PAT_LEFT_OUT   = 5'h10;
    localparam logic [PIN_W-1:0] PAT_RIGHT_OUT  = 5'h01;
    localparam logic [PIN_W-1:0] PAT_LEFT_3     = 5'h1C;
    localparam logic [PIN_W-1:0] PAT_LEFT_4     = 5'h1E;
    localparam logic [PIN_W-1:0] PAT_LEFT_2     = 5'h18;
    localparam logic [PIN_W-1:0] PAT_RIGHT_3    = 5'h07;
    localparam logic [PIN_W-1:0] PAT_RIGHT_4    = 5'h0F;
    localparam logic [PIN_W-1:0] PAT_RIGHT_2    = 5'h03;

    // Track status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL     = 3'd0,
        ST_LOST       = 3'd1,
        ST_STOP       = 3'd2,
        ST_SPIN_LEFT  = 3'd3,
        ST_SPIN_RIGHT = 3'd4
    } status_t;

    // One result transaction.
    typedef struct packed {
        logic [LOST_W-1:0]          lost_frames;
        logic                       right_turn_seen;
        logic                       left_turn_seen;
        status_t                    track_status;
        logic signed [NORM_W-1:0]   norm_steer_error;
        logic signed [STEER_W-1:0]  steer_error;
        logic [PIN_W-1:0]           pattern;
    } result_t;

    // Steering error per pattern in units of 1/256. Patterns without a fixed
    // entry hold the mean of the sensor weights over the set bits, truncated.
    function automatic logic signed [STEER_W-1:0] steer_lut(input logic [PIN_W-1:0] pat);
        logic signed [STEER_W-1:0] v;
        case (pat)
            5'h00: v = 13'sd0;
            5'h01: v = 13'sd2048;
            5'h02: v = 13'sd640;
            5'h03: v = 13'sd1536;
            5'h04: v = 13'sd0;
            5'h05: v = 13'sd1024;
            5'h06: v = 13'sd256;
            5'h07: v = 13'sd2048;
            5'h08: v = -13'sd640;
            5'h09: v = 13'sd512;
            5'h0A: v = 13'sd0;
            5'h0B: v = 13'sd682;
            5'h0C: v = -13'sd256;
            5'h0D: v = 13'sd341;
            5'h0E: v = 13'sd0;
            5'h0F: v = 13'sd2048;
            5'h10: v = -13'sd2048;
            5'h11: v = 13'sd0;
            5'h12: v = -13'sd512;
            5'h13: v = 13'sd341;
            5'h14: v = -13'sd1024;
            5'h15: v = 13'sd0;
            5'h16: v = -13'sd341;
            5'h17: v = 13'sd256;
            5'h18: v = -13'sd1536;
            5'h19: v = -13'sd341;
            5'h1A: v = -13'sd682;
            5'h1B: v = 13'sd0;
            5'h1C: v = -13'sd2048;
            5'h1D: v = -13'sd256;
            5'h1E: v = -13'sd2048;
            default: v = 13'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/lspc_classify.sv =====
// Maps a voted sensor pattern to steering error, status, turn flags and lost count.
module lspc_classify (
    input  logic [lspc_pkg::PIN_W-1:0]  pattern,
    input  logic [lspc_pkg::LOST_W-1:0] lost_run,
    input  logic [lspc_pkg::LOST_W-1:0] lost_thr,
    output lspc_pkg::result_t           result,
    output logic [lspc_pkg::LOST_W-1:0] lost_run_next
);
    import lspc_pkg::*;

    logic signed [STEER_W-1:0] err;
    logic signed [STEER_W-1:0] err_adj;
    logic signed [STEER_W-1:0] err_div;
    logic [LOST_W-1:0]         thr_eff;

    // Steering error from the table; divide by eight rounding toward zero.
    always_comb begin
        err     = steer_lut(pattern);
        err_adj = err + (err[STEER_W-1] ? 13'sd7 : 13'sd0);
        err_div = err_adj >>> 3;
    end

    // Lost-line counting and track status.
    always_comb begin
        thr_eff       = (lost_thr == '0) ? DEFAULT_THRESHOLD : lost_thr;
        lost_run_next = lost_run;
        result.track_status = ST_NORMAL;
        if (pattern == PAT_WHITE) begin
            if (lost_run != LOST_SAT) begin
                lost_run_next = lost_run + 8'd1;
            end
            result.track_status = (lost_run_next >= thr_eff) ? ST_LOST : ST_NORMAL;
        end else if (pattern == PAT_BLACK) begin
            result.track_status = ST_STOP;
        end else begin
            lost_run_next = '0;
            if (pattern == PAT_LEFT_3 || pattern == PAT_LEFT_4) begin
                result.track_status = ST_SPIN_LEFT;
            end else if (pattern == PAT_RIGHT_3 || pattern == PAT_RIGHT_4) begin
                result.track_status = ST_SPIN_RIGHT;
            end
        end
        result.pattern          = pattern;
        result.steer_error      = err;
        result.norm_steer_error = err_div[NORM_W-1:0];
        result.left_turn_seen   = (pattern == PAT_LEFT_4) || (pattern == PAT_LEFT_3) ||
                                  (pattern == PAT_LEFT_2);
        result.right_turn_seen  = (pattern == PAT_RIGHT_4) || (pattern == PAT_RIGHT_3) ||
                                  (pattern == PAT_RIGHT_2);
        result.lost_frames      = lost_run_next;
    end

endmodule

// ===== rtl/lspc_skid.sv =====
// Output register with a skid stage for result transactions.
module lspc_skid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  lspc_pkg::result_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lspc_pkg::result_t   out_data
);
    import lspc_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    // Upstream may push whenever the skid stage is free.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// ===== rtl/line_sensor_pattern_classifier_unit.sv =====
// Top level of the line-sensor pattern classifier.
// One sample of five sensor pins is taken per transaction, one per clock cycle
// while s_tready is high. Per-pin high counts are kept in registers; on the
// sample that completes a frame the counts are voted and classified in the same
// cycle and registered in the output register, or in the skid entry while that
// register holds a stalled result. The two-entry buffer lets samples flow while
// a result waits; s_tready drops only when both entries hold results.
// MAX_SAMPLES caps the frame length and sets the width of the sample counters.
module line_sensor_pattern_classifier_unit #(
    parameter int MAX_SAMPLES = 15
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration writes.
    input  logic                          cfg_wr_en,
    input  logic [lspc_pkg::IDX_W-1:0]    cfg_addr,
    input  logic [lspc_pkg::CFG_W-1:0]    cfg_wr_data,
    // Sample input.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: pin_levels[4:0], zero fill [7:5].
    input  logic [lspc_pkg::S_DATA_W-1:0] s_tdata,
    // Result output.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: pattern[4:0], steer_error[17:5], norm_steer_error[27:18],
    // track_status[30:28], left_turn_seen[31], right_turn_seen[32],
    // lost_frames[40:33], zero fill [47:41].
    output logic [lspc_pkg::M_DATA_W-1:0] m_tdata
);
    import lspc_pkg::*;

    localparam int NMAX  = (MAX_SAMPLES < 15) ? MAX_SAMPLES : 15;
    localparam int CNT_W = $clog2(NMAX + 1);
    localparam logic [MAJ_W-1:0] NMAX_V = MAJ_W'(NMAX);

    logic [MAJ_W-1:0]  maj_samples_reg;
    logic [LOST_W-1:0] lost_thr_reg;
    logic [CNT_W-1:0]  sample_cnt_reg;
    logic [CNT_W-1:0]  high_cnt_reg [PIN_W];
    logic [LOST_W-1:0] lost_cnt_reg;

    logic [MAJ_W-1:0]  n_raw;
    logic [MAJ_W-1:0]  n_clip;
    logic [CNT_W:0]    n_eff;
    logic [CNT_W:0]    maj_need;
    logic [CNT_W:0]    cnt_inc;
    logic              frame_close;
    logic              accept;
    logic [PIN_W-1:0]  pins;
    logic [PIN_W-1:0]  vote;
    logic [CNT_W:0]    high_next [PIN_W];
    logic [LOST_W-1:0] lost_cnt_next;
    logic              push_ready;
    result_t           cls_result;
    result_t           out_result;

    assign pins     = s_tdata[PIN_W-1:0];
    assign s_tready = push_ready;
    assign accept   = s_tvalid && push_ready;

    // Effective frame length and majority threshold.
    always_comb begin
        n_raw    = (maj_samples_reg == '0) ? DEFAULT_SAMPLES : maj_samples_reg;
        n_clip   = (n_raw > NMAX_V) ? NMAX_V : n_raw;
        n_eff    = (CNT_W+1)'(n_clip);
        maj_need = (n_eff >> 1) + 1'b1;
        cnt_inc  = {1'b0, sample_cnt_reg} + 1'b1;
        frame_close = (cnt_inc >= n_eff);
    end

    // Per-pin counts including this sample, and the vote.
    always_comb begin
        for (int i = 0; i < PIN_W; i++) begin
            high_next[i] = {1'b0, high_cnt_reg[i]} + {{CNT_W{1'b0}}, pins[PIN_W-1-i]};
            vote[PIN_W-1-i] = (high_next[i] >= maj_need);
        end
    end

    lspc_classify u_classify (
        .pattern       (vote),
        .lost_run      (lost_cnt_reg),
        .lost_thr      (lost_thr_reg),
        .result        (cls_result),
        .lost_run_next (lost_cnt_next)
    );

    lspc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept && frame_close),
        .in_ready  (push_ready),
        .in_data   (cls_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {{(M_DATA_W - $bits(result_t)){1'b0}}, out_result};

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            maj_samples_reg <= DEFAULT_SAMPLES;
            lost_thr_reg    <= DEFAULT_THRESHOLD;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MAJORITY_SAMPLES: maj_samples_reg <= cfg_wr_data[MAJ_W-1:0];
                REG_LOST_THRESHOLD:   lost_thr_reg    <= cfg_wr_data[LOST_W-1:0];
                default: ;
            endcase
        end
    end

    // Frame counters and lost-line counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_cnt_reg <= '0;
            lost_cnt_reg   <= '0;
            for (int i = 0; i < PIN_W; i++) begin
                high_cnt_reg[i] <= '0;
            end
        end else if (accept) begin
            if (frame_close) begin
                sample_cnt_reg <= '0;
                lost_cnt_reg   <= lost_cnt_next;
                for (int i = 0; i < PIN_W; i++) begin
                    high_cnt_reg[i] <= '0;
                end
            end else begin
                sample_cnt_reg <= cnt_inc[CNT_W-1:0];
                for (int i = 0; i < PIN_W; i++) begin
                    high_cnt_reg[i] <= high_next[i][CNT_W-1:0];
                end
            end
        end
    end

endmodule
